FILE: hw/rtl/qph_pkg.sv
// Shared codes, constants and controller/datapath interface types of the hash insert unit.
package qph_pkg;

   localparam int ACT_W  = 2;
   localparam int STAT_W = 2;
   localparam int SLOT_W = 7;
   localparam int SIZE_W = 8;

   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_READ   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

   localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] ST_READ     = 2'd2;
   localparam logic [STAT_W-1:0] ST_CLEARED  = 2'd3;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd11;
   localparam logic [SIZE_W-1:0] SIZE_MIN   = 8'd2;

   typedef struct packed {
      logic capture;
      logic mod_step;
      logic probe_step;
      logic write_key;
      logic set_full;
      logic set_read;
      logic clear_step;
      logic set_cleared;
      logic deliver;
   } cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             mod_last;
      logic             found;
      logic             exhausted;
      logic             clr_last;
      logic             out_free;
   } stat_type;

endpackage

FILE: hw/rtl/qph_ctrl.sv
// Controller state machine of the hash insert unit.
module qph_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output qph_pkg::cmd_type  cmd,
   input  qph_pkg::stat_type stat
);
   import qph_pkg::*;

   typedef enum logic [2:0] {
      INIT,
      IDLE,
      MOD,
      PROBE,
      READ_MEM,
      READ_RES,
      CLEAR,
      DELIVER
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;
   logic      accept;

   assign req_tready = ready_ff;
   assign accept     = req_tvalid && ready_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         INIT: begin
            cmd.clear_step = 1'b1;
            if (stat.clr_last) state_in = IDLE;
         end
         IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               case (stat.action)
                  ACT_INSERT: state_in = MOD;
                  ACT_READ:   state_in = READ_MEM;
                  ACT_CLEAR:  state_in = CLEAR;
                  default:    state_in = IDLE;
               endcase
            end
         end
         MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_last) state_in = PROBE;
         end
         PROBE: begin
            if (stat.found) begin
               cmd.write_key = 1'b1;
               state_in      = DELIVER;
            end else if (stat.exhausted) begin
               cmd.set_full = 1'b1;
               state_in     = DELIVER;
            end else begin
               cmd.probe_step = 1'b1;
            end
         end
         READ_MEM: state_in = READ_RES;
         READ_RES: begin
            cmd.set_read = 1'b1;
            state_in     = DELIVER;
         end
         CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clr_last) begin
               cmd.set_cleared = 1'b1;
               state_in        = DELIVER;
            end
         end
         DELIVER: begin
            if (stat.out_free) begin
               cmd.deliver = 1'b1;
               state_in    = IDLE;
            end
         end
         default: state_in = INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= INIT;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == IDLE);
      end
   end

`ifndef NO_ASSERTIONS
   a_deliver_free: assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |-> stat.out_free)
      else $error("result loaded while the output register is still occupied");
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.write_key, cmd.clear_step, cmd.capture}))
      else $error("conflicting memory or capture commands");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (accept && (stat.action == ACT_INSERT || stat.action == ACT_READ ||
                  stat.action == ACT_CLEAR)) |=> !req_tready)
      else $error("ready stayed high after a transaction was taken");
`endif

endmodule

FILE: hw/rtl/qph_datapath.sv
// Datapath of the hash insert unit: slot memory, key modulo, probe sequence and result register.
module qph_datapath #(
   parameter int TABLE_DEPTH = 128,
   parameter int KEY_BITS    = 17
) (
   input  logic                          clock,
   input  logic                          reset,
   input  qph_pkg::cmd_type              cmd,
   output qph_pkg::stat_type             stat,
   input  logic                          csr_wr_en,
   input  logic [qph_pkg::SIZE_W-1:0]    csr_wr_data,
   input  logic [qph_pkg::ACT_W-1:0]     req_action,
   input  logic [KEY_BITS-1:0]           req_key,
   input  logic [qph_pkg::SLOT_W-1:0]    req_slot_index,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [qph_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [qph_pkg::STAT_W-1:0]    rsp_status,
   output logic                          rsp_occupied,
   output logic [KEY_BITS-1:0]           rsp_value
);
   import qph_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int KC_W  = $clog2(KEY_BITS + 1);
   localparam int ENT_W = KEY_BITS + 1;
   localparam logic [SIZE_W-1:0] MAX_N =
      (TABLE_DEPTH > 255) ? 8'd255 : SIZE_W'(TABLE_DEPTH);

   // Entry layout: valid bit on top of the key.
   logic [ENT_W-1:0] mem [TABLE_DEPTH];
   logic [ENT_W-1:0] rd_ff;

   logic [SIZE_W-1:0] size_ff;
   logic [SIZE_W-1:0] n_ff, n_sel;
   logic [ACT_W-1:0]  act_ff;
   logic [KEY_BITS-1:0] key_ff, shift_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic [KC_W-1:0]   kcnt_ff;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W-1:0] q_ff, q_in, d_ff, d_in, slot_s;
   logic [SIZE_W:0]   iss_ff;
   logic              pend_ff;
   logic [SIZE_W-1:0] chk_ff;
   logic [IDX_W-1:0]  clr_ff;
   logic              issue;

   logic [SIZE_W:0]   n9, r9, rsub, qsum, dsum, ssum;
   logic [31:0]       s32, idx32, chk32;
   logic [IDX_W-1:0]  rd_addr, wr_addr;
   logic              idx_ok, occ_rd;

   logic [SLOT_W-1:0]   res_slot_ff;
   logic [STAT_W-1:0]   res_status_ff;
   logic                res_occ_ff;
   logic [KEY_BITS-1:0] res_value_ff;
   logic                rsp_valid_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [STAT_W-1:0]   rsp_status_ff;
   logic                rsp_occ_ff;
   logic [KEY_BITS-1:0] rsp_value_ff;

   always_comb begin
      if (size_ff < SIZE_MIN) n_sel = SIZE_MIN;
      else if (size_ff > MAX_N) n_sel = MAX_N;
      else n_sel = size_ff;
   end

   assign n9 = {1'b0, n_ff};

   // One restoring step of key mod n per cycle, most significant key bit first.
   assign r9     = {rem_ff, shift_ff[KEY_BITS-1]};
   assign rsub   = (r9 >= n9) ? (r9 - n9) : r9;
   assign rem_in = rsub[SIZE_W-1:0];

   // i*i mod n advances by the odd step (2i+1) mod n, each sum below 2n.
   assign qsum   = {1'b0, q_ff} + {1'b0, d_ff};
   assign dsum   = {1'b0, d_ff} + 9'd2;
   assign ssum   = {1'b0, rem_ff} + {1'b0, q_ff};
   assign q_in   = (qsum >= n9) ? SIZE_W'(qsum - n9) : qsum[SIZE_W-1:0];
   assign d_in   = (dsum >= n9) ? SIZE_W'(dsum - n9) : dsum[SIZE_W-1:0];
   assign slot_s = (ssum >= n9) ? SIZE_W'(ssum - n9) : ssum[SIZE_W-1:0];
   assign issue  = iss_ff < n9;

   assign s32     = 32'(slot_s);
   assign idx32   = 32'(idx_ff);
   assign chk32   = 32'(chk_ff);
   assign idx_ok  = idx32 < 32'(TABLE_DEPTH);
   assign rd_addr = cmd.probe_step ? s32[IDX_W-1:0] : idx32[IDX_W-1:0];
   assign wr_addr = chk32[IDX_W-1:0];
   assign occ_rd  = idx_ok && rd_ff[KEY_BITS];

   assign stat.action    = (cmd.capture || act_ff == ACT_INSERT) ? req_action : act_ff;
   assign stat.mod_last  = (kcnt_ff == KC_W'(KEY_BITS - 1));
   assign stat.found     = pend_ff && !rd_ff[KEY_BITS];
   assign stat.exhausted = !pend_ff && (iss_ff == n9);
   assign stat.clr_last  = (clr_ff == IDX_W'(TABLE_DEPTH - 1));
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.clear_step) mem[clr_ff] <= '0;
      else if (cmd.write_key) mem[wr_addr] <= {1'b1, key_ff};
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_RESET;
         n_ff         <= SIZE_MIN;
         act_ff       <= ACT_READ;
         pend_ff      <= 1'b0;
         iss_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) size_ff <= csr_wr_data;
         if (cmd.capture) begin
            n_ff    <= n_sel;
            act_ff  <= req_action;
            pend_ff <= 1'b0;
            iss_ff  <= '0;
         end else if (cmd.probe_step) begin
            pend_ff <= issue;
            if (issue) iss_ff <= iss_ff + 1'b1;
         end
         if (cmd.clear_step) clr_ff <= stat.clr_last ? '0 : clr_ff + 1'b1;
         if (cmd.deliver) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff   <= req_key;
         shift_ff <= req_key;
         idx_ff   <= req_slot_index;
         kcnt_ff  <= '0;
         rem_ff   <= '0;
         q_ff     <= '0;
         d_ff     <= 8'd1;
      end
      if (cmd.mod_step) begin
         rem_ff   <= rem_in;
         shift_ff <= shift_ff << 1;
         kcnt_ff  <= kcnt_ff + 1'b1;
      end
      if (cmd.probe_step && issue) begin
         chk_ff <= slot_s;
         q_ff   <= q_in;
         d_ff   <= d_in;
      end
      if (cmd.write_key) begin
         res_slot_ff   <= chk_ff[SLOT_W-1:0];
         res_status_ff <= ST_INSERTED;
         res_occ_ff    <= 1'b0;
         res_value_ff  <= '0;
      end
      if (cmd.set_full) begin
         res_slot_ff   <= '0;
         res_status_ff <= ST_FULL;
         res_occ_ff    <= 1'b0;
         res_value_ff  <= '0;
      end
      if (cmd.set_read) begin
         res_slot_ff   <= idx_ff;
         res_status_ff <= ST_READ;
         res_occ_ff    <= occ_rd;
         res_value_ff  <= occ_rd ? rd_ff[KEY_BITS-1:0] : '0;
      end
      if (cmd.set_cleared) begin
         res_slot_ff   <= '0;
         res_status_ff <= ST_CLEARED;
         res_occ_ff    <= 1'b0;
         res_value_ff  <= '0;
      end
      if (cmd.deliver) begin
         rsp_slot_ff   <= res_slot_ff;
         rsp_status_ff <= res_status_ff;
         rsp_occ_ff    <= res_occ_ff;
         rsp_value_ff  <= res_value_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_occupied = rsp_occ_ff;
   assign rsp_value    = rsp_value_ff;

`ifndef NO_ASSERTIONS
   a_found_in_table: assert property (@(posedge clock) disable iff (reset)
      stat.found |-> (chk_ff < n_ff))
      else $error("empty slot found outside the table size in use");
   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      iss_ff <= n9)
      else $error("more probes issued than slots in use");
`endif

endmodule

FILE: hw/rtl/quadratic_probe_hash_insert_unit.sv
// Top level of the quadratic probing hash table insert unit.
//
//   Channel  Direction  tdata (low bit up)                 tuser
//   req_     in         key, slot_index                     action
//   rsp_     out        slot, occupied, value               status
//   csr_     in         table_size on csr_wr_data           -
//
// Insert runs the bit-serial key modulo, then probes the slot memory until an empty slot
// is found or every slot in use has been tried (table full), then delivers the result.
// Read fetches the addressed row and delivers its contents; clear empties one memory row
// per cycle, then delivers a cleared status.
// After reset a clearing pass over all TABLE_DEPTH rows runs before the first transaction.
// A new transaction is taken while a result still waits in the output register.
module quadratic_probe_hash_insert_unit #(
   parameter int TABLE_DEPTH = 128,
   parameter int KEY_BITS    = 17
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [((KEY_BITS+14)/8)*8-1:0] req_tdata,  // key, slot_index
   input  logic [qph_pkg::ACT_W-1:0]  req_tuser,      // action
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [((KEY_BITS+15)/8)*8-1:0] rsp_tdata,  // slot, occupied, value
   output logic [qph_pkg::STAT_W-1:0] rsp_tuser,      // status
   input  logic                       csr_wr_en,
   input  logic [qph_pkg::SIZE_W-1:0] csr_wr_data
);
   import qph_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   logic [KEY_BITS-1:0] req_key;
   logic [SLOT_W-1:0]   req_slot_index;
   logic [SLOT_W-1:0]   rsp_slot;
   logic                rsp_occupied;
   logic [KEY_BITS-1:0] rsp_value;

   assign req_key        = req_tdata[KEY_BITS-1:0];
   assign req_slot_index = req_tdata[KEY_BITS+SLOT_W-1:KEY_BITS];

   always_comb begin
      rsp_tdata                         = '0;
      rsp_tdata[SLOT_W-1:0]             = rsp_slot;
      rsp_tdata[SLOT_W]                 = rsp_occupied;
      rsp_tdata[KEY_BITS+SLOT_W:SLOT_W+1] = rsp_value;
   end

   qph_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   qph_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_action     (req_tuser),
      .req_key        (req_key),
      .req_slot_index (req_slot_index),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_slot       (rsp_slot),
      .rsp_status     (rsp_tuser),
      .rsp_occupied   (rsp_occupied),
      .rsp_value      (rsp_value)
   );

endmodule
